/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/ita_pkg.sv */
// Types, constants and the character lookup of the integer to ASCII formatter.
// No dependencies; used by the interfaces and the top level.
package ita_pkg;

    localparam int VALUE_W         = 64;
    localparam int PAD_W           = 6;
    localparam int DEF_MAX_WIDTH   = 63;
    localparam int DEF_DIGIT_SLOTS = 20;

    localparam logic [1:0] MODE_UDEC = 2'd0;
    localparam logic [1:0] MODE_HEX  = 2'd1;
    localparam logic [1:0] MODE_SDEC = 2'd2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [15:0][7:0] HEX_UPPER = {
        8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };
    localparam logic [15:0][7:0] HEX_LOWER = {
        8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         mode;
        logic               upper_case;
        logic [PAD_W-1:0]   pad_width;
        logic               zero_fill;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_word;

    function automatic logic [7:0] f_digit_char(input logic [3:0] digit, input logic upper);
        f_digit_char = upper ? HEX_UPPER[digit] : HEX_LOWER[digit];
    endfunction

endpackage

/* hdl/ita_if.sv */
// Handshake channels of the integer to ASCII formatter: request in, character out.
// Depends on ita_pkg for the word types.
interface ita_in_if;
    logic              valid;
    logic              ready;
    ita_pkg::t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ita_out_if;
    logic               valid;
    logic               ready;
    ita_pkg::t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* hdl/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter: a 64-bit value in, its decimal or hex characters out.
// Depends on ita_pkg, ita_if.sv and assert_macros.svh.
//
// Takes one request word (value, mode, case, minimum width, fill) and returns the
// characters of the number most significant first, last one flagged: a minus sign
// for negative signed values, then fill characters up to the minimum width in the
// unsigned modes, then the digits. Decimal conversion runs bit-serially through a
// BCD shift register, one value bit per cycle; hex loads its nibbles directly.
// Leading zero digits then shift out one digit per cycle, and each character goes
// out through the output register. A new request is taken once the last character
// of the previous one sits in the output register.
module integer_to_ascii_formatter #(
    parameter int MAX_WIDTH   = ita_pkg::DEF_MAX_WIDTH,
    parameter int DIGIT_SLOTS = ita_pkg::DEF_DIGIT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ita_in_if.sink      i_in,
    ita_out_if.source   o_out
);
    import ita_pkg::*;

    localparam int DIG_W = DIGIT_SLOTS * 4;
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int BIT_W = $clog2(VALUE_W);
    localparam int CMP_W = (CNT_W > PAD_W) ? CNT_W : PAD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         r_state;
    logic [VALUE_W-1:0] r_bin;
    logic [DIG_W-1:0]   r_dig;
    logic [DIG_W-1:0]   n_dig_dd;
    logic [CNT_W-1:0]   r_cnt;
    logic [BIT_W-1:0]   r_bitcnt;
    logic [PAD_W-1:0]   r_width;
    logic [PAD_W-1:0]   r_pad;
    logic               r_neg;
    logic               r_signed;
    logic               r_zfill;
    logic               r_upper;
    logic               r_ovalid;
    t_out_word          r_oword;

    logic               in_fire;
    logic               slot_free;
    logic               is_hex;
    logic               is_sdec;
    logic               neg_in;
    logic [VALUE_W-1:0] mag_in;
    logic [PAD_W-1:0]   width_clip;
    logic [3:0]         top_digit;

    assign in_fire    = i_in.valid && i_in.ready;
    assign slot_free  = !r_ovalid || o_out.ready;
    assign is_hex     = (i_in.data.mode == MODE_HEX);
    assign is_sdec    = (i_in.data.mode == MODE_SDEC);
    assign neg_in     = is_sdec && i_in.data.value[VALUE_W-1];
    assign mag_in     = neg_in ? (VALUE_W'(0) - i_in.data.value) : i_in.data.value;
    assign width_clip = (i_in.data.pad_width > PAD_W'(MAX_WIDTH)) ? PAD_W'(MAX_WIDTH)
                                                                   : i_in.data.pad_width;
    assign top_digit  = r_dig[DIG_W-1 -: 4];

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_oword;

    // add 3 to every BCD digit of 5 or more, then shift in the next value bit
    always_comb begin
        logic [DIG_W-1:0] adj;
        adj = r_dig;
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            if (r_dig[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = r_dig[i*4 +: 4] + 4'd3;
            end
        end
        n_dig_dd = {adj[DIG_W-2:0], r_bin[VALUE_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_pad    <= '0;
            r_bitcnt <= '0;
            r_neg    <= 1'b0;
        end else begin
            // hold while stalled, load in emit, drop once taken
            r_ovalid <= (r_state == ST_EMIT) || !slot_free;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_neg    <= neg_in;
                        r_signed <= is_sdec;
                        r_zfill  <= i_in.data.zero_fill;
                        r_upper  <= i_in.data.upper_case;
                        r_width  <= width_clip;
                        r_cnt    <= CNT_W'(DIGIT_SLOTS);
                        r_bitcnt <= '0;
                        r_bin    <= mag_in;
                        if (is_hex) begin
                            r_dig   <= DIG_W'(mag_in);
                            r_state <= ST_NORM;
                        end else begin
                            r_dig   <= '0;
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    r_dig    <= n_dig_dd;
                    r_bin    <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_bitcnt <= r_bitcnt + BIT_W'(1);
                    if (r_bitcnt == BIT_W'(VALUE_W - 1)) begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // drop leading zero digits, keep at least one
                    if (top_digit == 4'd0 && r_cnt > CNT_W'(1)) begin
                        r_dig <= {r_dig[DIG_W-5:0], 4'd0};
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        if (!r_signed && CMP_W'(r_width) > CMP_W'(r_cnt)) begin
                            r_pad <= PAD_W'(CMP_W'(r_width) - CMP_W'(r_cnt));
                        end else begin
                            r_pad <= '0;
                        end
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        priority if (r_neg) begin
                            r_oword.out_char  <= CHAR_MINUS;
                            r_oword.last_char <= 1'b0;
                            r_neg             <= 1'b0;
                        end else if (r_pad != '0) begin
                            r_oword.out_char  <= r_zfill ? CHAR_ZERO : CHAR_SPACE;
                            r_oword.last_char <= 1'b0;
                            r_pad             <= r_pad - PAD_W'(1);
                        end else begin
                            r_oword.out_char  <= f_digit_char(top_digit, r_upper);
                            r_oword.last_char <= (r_cnt == CNT_W'(1));
                            r_dig             <= {r_dig[DIG_W-5:0], 4'd0};
                            r_cnt             <= r_cnt - CNT_W'(1);
                            if (r_cnt == CNT_W'(1)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_emit_has_digits, i_clk, i_rst_n,
        (r_state == ST_EMIT) && (r_cnt == '0), "emit phase entered with no digits")
    `ASSERT_CLK(a_signed_no_pad, i_clk, i_rst_n,
        (r_state == ST_EMIT) && r_signed |-> (r_pad == '0),
        "padding pending on a signed request")
    `ASSERT_CLK(a_accept_starts, i_clk, i_rst_n,
        in_fire |=> (r_state == ST_CONV) || (r_state == ST_NORM),
        "accepted request did not start conversion")
    `ASSERT_CLK(a_last_ends_item, i_clk, i_rst_n,
        (r_state == ST_EMIT) && slot_free && !r_neg && (r_pad == '0) &&
        (r_cnt == CNT_W'(1)) |=> (r_state == ST_IDLE) && r_oword.last_char,
        "final digit did not close the request")

endmodule
